### hw/rtl/ppu_pkg.sv
// shared types and constants of the ascii ppm pixel parser
package ppu_pkg;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 80;
   localparam int RSP_TUSER_W = 2;
   localparam int ACC_W       = 16;

   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_PIXEL  = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_BAD_CHAR = 2'd1;
   localparam logic [1:0] ERR_ZERO_DIM = 2'd2;
   localparam logic [1:0] ERR_EARLY    = 2'd3;

   typedef enum logic [1:0] {
      CLS_DIGIT = 2'd0,
      CLS_BLANK = 2'd1,
      CLS_HASH  = 2'd2,
      CLS_OTHER = 2'd3
   } char_class_type;

   // one classified byte as it waits in the queue
   typedef struct packed {
      char_class_type cls;
      logic           is_lf;
      logic           is_eol;
      logic [3:0]     digit;
      logic           eos;
   } byte_info_type;

   typedef enum logic [4:0] {
      PH_SKIP   = 5'b00001,
      PH_HEADER = 5'b00010,
      PH_PIXELS = 5'b00100,
      PH_DONE   = 5'b01000,
      PH_ERROR  = 5'b10000
   } phase_type;

endpackage

### hw/rtl/ppu_front.sv
// front end: accepts input bytes and classifies them for the parser
module ppu_front (
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tlast,
   input  logic                  queue_full,
   output logic                  push,
   output ppu_pkg::byte_info_type push_info
);
   import ppu_pkg::*;

   logic is_digit;
   logic is_blank;

   assign req_tready = ~queue_full;
   assign push       = req_tvalid & ~queue_full;

   assign is_digit = (req_tdata >= CHAR_ZERO) && (req_tdata <= CHAR_NINE);
   // space, tab, lf, vt, ff, cr
   assign is_blank = (req_tdata == CHAR_SPACE) ||
                     ((req_tdata >= CHAR_TAB) && (req_tdata <= CHAR_CR));

   always_comb begin
      priority if (is_digit) begin
         push_info.cls = CLS_DIGIT;
      end else if (is_blank) begin
         push_info.cls = CLS_BLANK;
      end else if (req_tdata == CHAR_HASH) begin
         push_info.cls = CLS_HASH;
      end else begin
         push_info.cls = CLS_OTHER;
      end
      push_info.is_lf  = (req_tdata == CHAR_LF);
      push_info.is_eol = (req_tdata == CHAR_LF) || (req_tdata == CHAR_CR);
      push_info.digit  = 4'(req_tdata - CHAR_ZERO);
      push_info.eos    = req_tlast;
   end

endmodule

### hw/rtl/ppu_queue.sv
// two-entry queue of classified bytes between front and back
module ppu_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ppu_pkg::byte_info_type push_info,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output ppu_pkg::byte_info_type head_info
);
   import ppu_pkg::*;

   byte_info_type entry_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_info  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_info;
      end
   end

endmodule

### hw/rtl/ppu_back.sv
// back end: number parsing, header and pixel assembly, result register
module ppu_back #(
   parameter int DIM_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  ppu_pkg::byte_info_type         head_info,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [ppu_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [ppu_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   output logic                          rsp_tlast
);
   import ppu_pkg::*;

   localparam int LEFT_W = 2 * DIM_BITS;
   localparam logic [ACC_W-1:0] DIM_MAX = ACC_W'((1 << DIM_BITS) - 1);

   phase_type           phase_ff, phase_in;
   logic                comment_ff, comment_in;
   logic                innum_ff, innum_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [1:0]          fidx_ff, fidx_in;
   logic [DIM_BITS-1:0] width_ff, width_in;
   logic [DIM_BITS-1:0] height_ff, height_in;
   logic [7:0]          red_ff, red_in;
   logic [7:0]          green_ff, green_in;
   logic [LEFT_W-1:0]   left_ff, left_in;

   logic                active, in_header;
   logic                digit_case, sep_case, bad_case, end_case;
   logic [ACC_W-1:0]    acc_base, limit, acc_new, end_val;
   logic [ACC_W+3:0]    prod;

   logic                res_valid;
   logic [1:0]          res_kind, res_err;
   logic [15:0]         res_width, res_height, res_max;
   logic [7:0]          res_red, res_green, res_blue;
   logic                res_last;

   logic                out_valid_ff;
   logic [1:0]          out_kind_ff, out_err_ff;
   logic [15:0]         out_width_ff, out_height_ff, out_max_ff;
   logic [7:0]          out_red_ff, out_green_ff, out_blue_ff;
   logic                out_last_ff;

   assign pop = head_valid & (~out_valid_ff | rsp_tready);

   assign in_header  = (phase_ff == PH_HEADER);
   assign active     = in_header || (phase_ff == PH_PIXELS);
   assign digit_case = active & ~comment_ff & (head_info.cls == CLS_DIGIT);
   assign sep_case   = active & ~comment_ff &
                       ((head_info.cls == CLS_BLANK) || (head_info.cls == CLS_HASH));
   assign bad_case   = active & ~comment_ff & (head_info.cls == CLS_OTHER);
   // a number ends at a separator, or at the final byte when that byte is a digit
   assign end_case   = (sep_case & innum_ff) | (digit_case & head_info.eos);

   // accumulator times ten plus digit, saturated in the header, wrapped for samples
   always_comb begin
      acc_base = innum_ff ? acc_ff : '0;
      prod     = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0} +
                 (ACC_W+4)'(head_info.digit);
      limit    = (fidx_ff < 2'd2) ? DIM_MAX : '1;
      if (in_header) begin
         acc_new = (prod > (ACC_W+4)'(limit)) ? limit : prod[ACC_W-1:0];
      end else begin
         acc_new = prod[ACC_W-1:0];
      end
      end_val = digit_case ? acc_new : acc_ff;
   end

   always_comb begin
      phase_in   = phase_ff;
      comment_in = comment_ff;
      innum_in   = innum_ff;
      acc_in     = acc_ff;
      fidx_in    = fidx_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      red_in     = red_ff;
      green_in   = green_ff;
      left_in    = left_ff;

      res_valid  = 1'b0;
      res_kind   = KIND_HEADER;
      res_err    = ERR_NONE;
      res_width  = '0;
      res_height = '0;
      res_max    = '0;
      res_red    = '0;
      res_green  = '0;
      res_blue   = '0;
      res_last   = 1'b0;

      if (pop) begin
         if ((phase_ff == PH_SKIP) && head_info.is_lf) begin
            phase_in = PH_HEADER;
         end
         if (active && comment_ff && head_info.is_eol) begin
            comment_in = 1'b0;
         end
         if (sep_case && (head_info.cls == CLS_HASH)) begin
            comment_in = 1'b1;
         end
         if (digit_case) begin
            acc_in   = acc_new;
            innum_in = 1'b1;
         end
         if (bad_case) begin
            res_valid = 1'b1;
            res_kind  = KIND_ERROR;
            res_err   = ERR_BAD_CHAR;
            phase_in  = PH_ERROR;
         end

         if (end_case) begin
            innum_in = 1'b0;
            acc_in   = '0;
            if (in_header) begin
               priority if (fidx_ff == 2'd0) begin
                  width_in = end_val[DIM_BITS-1:0];
                  fidx_in  = 2'd1;
               end else if (fidx_ff == 2'd1) begin
                  height_in = end_val[DIM_BITS-1:0];
                  fidx_in   = 2'd2;
               end else begin
                  fidx_in   = 2'd0;
                  res_valid = 1'b1;
                  if ((width_ff == '0) || (height_ff == '0)) begin
                     res_kind = KIND_ERROR;
                     res_err  = ERR_ZERO_DIM;
                     phase_in = PH_ERROR;
                  end else begin
                     left_in    = LEFT_W'(width_ff) * LEFT_W'(height_ff);
                     res_kind   = KIND_HEADER;
                     res_width  = 16'(width_ff);
                     res_height = 16'(height_ff);
                     res_max    = end_val;
                     phase_in   = PH_PIXELS;
                  end
               end
            end else begin
               priority if (fidx_ff == 2'd0) begin
                  red_in  = end_val[7:0];
                  fidx_in = 2'd1;
               end else if (fidx_ff == 2'd1) begin
                  green_in = end_val[7:0];
                  fidx_in  = 2'd2;
               end else begin
                  fidx_in   = 2'd0;
                  left_in   = left_ff - LEFT_W'(1);
                  res_valid = 1'b1;
                  res_kind  = KIND_PIXEL;
                  res_red   = red_ff;
                  res_green = green_ff;
                  res_blue  = end_val[7:0];
                  res_last  = (left_ff == LEFT_W'(1));
                  if (left_ff == LEFT_W'(1)) begin
                     phase_in = PH_DONE;
                  end
               end
            end
         end

         if (head_info.eos) begin
            // end of file before the image is complete overrides any header or pixel
            if ((phase_in == PH_SKIP) || (phase_in == PH_HEADER) ||
                (phase_in == PH_PIXELS)) begin
               res_valid  = 1'b1;
               res_kind   = KIND_ERROR;
               res_err    = ERR_EARLY;
               res_width  = '0;
               res_height = '0;
               res_max    = '0;
               res_red    = '0;
               res_green  = '0;
               res_blue   = '0;
               res_last   = 1'b0;
            end
            phase_in   = PH_SKIP;
            comment_in = 1'b0;
            innum_in   = 1'b0;
            acc_in     = '0;
            fidx_in    = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SKIP;
         comment_ff <= 1'b0;
         innum_ff   <= 1'b0;
         fidx_ff    <= 2'd0;
      end else begin
         phase_ff   <= phase_in;
         comment_ff <= comment_in;
         innum_ff   <= innum_in;
         fidx_ff    <= fidx_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      width_ff  <= width_in;
      height_ff <= height_in;
      red_ff    <= red_in;
      green_ff  <= green_in;
      left_ff   <= left_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (pop && res_valid) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && res_valid) begin
         out_kind_ff   <= res_kind;
         out_err_ff    <= res_err;
         out_width_ff  <= res_width;
         out_height_ff <= res_height;
         out_max_ff    <= res_max;
         out_red_ff    <= res_red;
         out_green_ff  <= res_green;
         out_blue_ff   <= res_blue;
         out_last_ff   <= res_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {6'b0, out_err_ff, out_blue_ff, out_green_ff, out_red_ff,
                        out_max_ff, out_height_ff, out_width_ff};

endmodule

### hw/rtl/ppm_ascii_pixel_parser_unit.sv
// top level of the ascii ppm (p3) pixel parser
//
// req channel: one file character per item, tlast on the final byte of the file
// rsp channel: one item per header, pixel or error; tuser gives its kind
// (header, pixel, error) and tlast marks the pixel completing width times height
// the first line is skipped, '#' comments run to lf or cr, numbers are decimal
// throughput: one byte per clock while rsp is not stalled, whatever the byte contents
// a result shows on rsp once the byte that ends it has passed through the queue
// and the parser has written the result into the result register
// the front classifies bytes into a two-entry queue; the parser pops one entry
// a cycle while the result register is empty or being drained
// when rsp stalls with a result held, the parser waits and the queue fills;
// req_tready drops only once both queue entries are taken
// reset clears the queue, the result register and the parser to the state
// of skipping the first line; the byte with tlast returns the parser there too
// after an error, bytes are dropped up to the end of the file
module ppm_ascii_pixel_parser_unit #(
   parameter int DIM_BITS = 16   // width and height saturate at 2**DIM_BITS-1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ppu_pkg::REQ_TDATA_W-1:0] req_tdata,   // byte_in[7:0]
   input  logic                            req_tlast,   // end_of_stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // image_width[15:0], image_height[31:16], max_value[47:32], red[55:48],
   // green[63:56], blue[71:64], error_code[73:72], zero fill[79:74]
   output logic [ppu_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [ppu_pkg::RSP_TUSER_W-1:0] rsp_tuser,   // kind[1:0]
   output logic                            rsp_tlast    // last_pixel
);
   import ppu_pkg::*;

   logic          push, queue_full, head_valid, pop;
   byte_info_type push_info, head_info;

   // classify incoming characters
   ppu_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_info  (push_info)
   );

   // decouples byte intake from result stalls
   ppu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_info  (push_info),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_info  (head_info)
   );

   // parsing state and result register
   ppu_back #(
      .DIM_BITS (DIM_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_info  (head_info),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### hw/rtl/ppu_checker.sv
// port-level checks of the ascii ppm pixel parser, bound to the top level
module ppu_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [ppu_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [ppu_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   input  logic                            rsp_tlast
);
   import ppu_pkg::*;

   // held result keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp item changed while stalled");

   // nothing is shown in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // last marks only pixels
   a_last_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == KIND_PIXEL)
      else $error("last flag on a non-pixel item");

   // error code present exactly on error items
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser == KIND_ERROR) == (rsp_tdata[73:72] != ERR_NONE)))
      else $error("error code does not match kind");

   // only header, pixel and error kinds appear
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == KIND_HEADER) || (rsp_tuser == KIND_PIXEL) ||
      (rsp_tuser == KIND_ERROR))
      else $error("unknown result kind");

endmodule

bind ppm_ascii_pixel_parser_unit ppu_checker u_checker (.*);

### tb/sv/tb_ppm_ascii_pixel_parser_unit.sv
// self-checking testbench of the ascii ppm (p3) pixel parser unit
module tb_ppm_ascii_pixel_parser_unit;
   import ppu_pkg::*;

   localparam int DIM_BITS     = 16;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BYTES = 600;
   localparam int STEADY_BYTES = 250;
   localparam logic [7:0] CHAR_VT = 8'h0B;
   localparam logic [7:0] CHAR_FF = 8'h0C;

   // one result item as the parser should produce it
   typedef struct {
      logic [1:0]  kind;
      logic [15:0] width;
      logic [15:0] height;
      logic [15:0] max_val;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        last;
      logic [1:0]  err;
   } ppm_result_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   rsp_tlast;

   ppm_ascii_pixel_parser_unit #(.DIM_BITS(DIM_BITS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // parser state as predicted from the accepted bytes
   phase_type   phase;
   bit          comment_open;
   bit          number_open;
   logic [31:0] accum;
   logic [1:0]  field_idx;
   logic [15:0] width_r;
   logic [15:0] height_r;
   logic [15:0] max_r;
   logic [7:0]  red_r;
   logic [7:0]  green_r;
   logic [31:0] pixels_left;

   ppm_result_type step_result;
   bit             step_has_result;
   ppm_result_type pending_results[$];

   logic [7:0]  file_bytes[$];
   bit          steady = 1'b0;   // no idling on either side while set
   int          mismatches;
   int          results_seen;
   int          header_count;
   int          pixel_count;
   int          error_count;
   int          files_sent;
   int          bytes_sent;
   int          parsed_bytes;    // bytes taken while the parser was not discarding
   int          cycle_count;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit is_blank(logic [7:0] b);
      return b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR);
   endfunction

   function automatic bit is_digit(logic [7:0] b);
      return b >= CHAR_ZERO && b <= CHAR_NINE;
   endfunction

   // -------- predictor --------

   task clear_parser();
      phase        = PH_SKIP;
      comment_open = 1'b0;
      number_open  = 1'b0;
      accum        = '0;
      field_idx    = '0;
      width_r      = '0;
      height_r     = '0;
      max_r        = '0;
      red_r        = '0;
      green_r      = '0;
      pixels_left  = '0;
   endtask

   task flag_error(input logic [1:0] code);
      step_result      = '{default: '0};
      step_result.kind = KIND_ERROR;
      step_result.err  = code;
      step_has_result  = 1'b1;
      phase            = PH_ERROR;
   endtask

   task push_digit(input logic [3:0] d);
      logic [31:0] v;
      logic [31:0] limit;
      v = number_open ? accum : 32'd0;
      v = v * 10 + 32'(d);
      if (phase == PH_HEADER) begin
         // width and height clamp at the dimension limit, the max value at 16 bits
         limit = (field_idx < 2) ? (32'd1 << DIM_BITS) - 1 : 32'd65535;
         if (v > limit) v = limit;
      end else begin
         v = v & 32'hFFFF;
      end
      accum       = v;
      number_open = 1'b1;
   endtask

   task close_number();
      logic [31:0] v;
      v           = accum;
      number_open = 1'b0;
      accum       = '0;
      if (phase == PH_HEADER) begin
         case (field_idx)
            2'd0: begin
               width_r   = v[15:0];
               field_idx = 2'd1;
            end
            2'd1: begin
               height_r  = v[15:0];
               field_idx = 2'd2;
            end
            default: begin
               max_r     = v[15:0];
               field_idx = 2'd0;
               if (width_r == 0 || height_r == 0) begin
                  flag_error(ERR_ZERO_DIM);
                  return;
               end
               pixels_left         = {16'd0, width_r} * {16'd0, height_r};
               step_result         = '{default: '0};
               step_result.kind    = KIND_HEADER;
               step_result.width   = width_r;
               step_result.height  = height_r;
               step_result.max_val = max_r;
               step_has_result     = 1'b1;
               phase               = PH_PIXELS;
            end
         endcase
      end else begin
         case (field_idx)
            2'd0: begin
               red_r     = v[7:0];
               field_idx = 2'd1;
            end
            2'd1: begin
               green_r   = v[7:0];
               field_idx = 2'd2;
            end
            default: begin
               field_idx         = 2'd0;
               pixels_left       = pixels_left - 1;
               step_result       = '{default: '0};
               step_result.kind  = KIND_PIXEL;
               step_result.red   = red_r;
               step_result.green = green_r;
               step_result.blue  = v[7:0];
               step_result.last  = (pixels_left == 0);
               step_has_result   = 1'b1;
               if (pixels_left == 0) phase = PH_DONE;
            end
         endcase
      end
   endtask

   // advance the predicted parser by one accepted byte
   task parse_byte(input logic [7:0] b, input logic eos);
      step_has_result = 1'b0;
      step_result     = '{default: '0};
      if (phase != PH_DONE && phase != PH_ERROR) parsed_bytes++;
      if (phase == PH_SKIP) begin
         if (b == CHAR_LF) phase = PH_HEADER;
      end else if (phase == PH_HEADER || phase == PH_PIXELS) begin
         if (comment_open) begin
            if (b == CHAR_LF || b == CHAR_CR) comment_open = 1'b0;
         end else if (is_digit(b)) begin
            push_digit(4'(b - CHAR_ZERO));
         end else if (is_blank(b) || b == CHAR_HASH) begin
            if (number_open) close_number();
            if (b == CHAR_HASH) comment_open = 1'b1;
         end else begin
            flag_error(ERR_BAD_CHAR);
         end
      end
      if (eos) begin
         // a number cut by the end of file still counts, then anything unfinished is early
         if ((phase == PH_HEADER || phase == PH_PIXELS) && number_open) close_number();
         if (phase == PH_SKIP || phase == PH_HEADER || phase == PH_PIXELS)
            flag_error(ERR_EARLY);
         clear_parser();
      end
      if (step_has_result) pending_results.push_back(step_result);
   endtask

   // -------- byte source --------

   task send_byte(input logic [7:0] b, input logic eos);
      while (!steady && $urandom_range(99) < 10) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eos;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      parse_byte(b, eos);
   endtask

   // the final byte of the file carries tlast
   task send_file();
      for (int i = 0; i < file_bytes.size(); i++)
         send_byte(file_bytes[i], i == file_bytes.size() - 1);
      files_sent++;
   endtask

   task send_text(input string s);
      file_bytes.delete();
      for (int i = 0; i < s.len(); i++) file_bytes.push_back(s[i]);
      send_file();
   endtask

   // -------- random file construction --------

   function automatic logic [7:0] rand_blank();
      case ($urandom_range(5))
         0: return CHAR_SPACE;
         1: return CHAR_TAB;
         2: return CHAR_LF;
         3: return CHAR_VT;
         4: return CHAR_FF;
         default: return CHAR_CR;
      endcase
   endfunction

   // anything that cannot end a line
   function automatic logic [7:0] rand_line_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (b == CHAR_LF || b == CHAR_CR);
      return b;
   endfunction

   // a byte the parser must reject
   function automatic logic [7:0] rand_stray_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (is_blank(b) || is_digit(b) || b == CHAR_HASH);
      return b;
   endfunction

   task add_number(input int unsigned v);
      string s;
      if ($urandom_range(9) == 0)
         repeat ($urandom_range(1, 3)) file_bytes.push_back(CHAR_ZERO);
      s = $sformatf("%0d", v);
      for (int i = 0; i < s.len(); i++) file_bytes.push_back(s[i]);
   endtask

   task add_separator();
      if ($urandom_range(7) == 0) begin
         file_bytes.push_back(CHAR_HASH);
         repeat ($urandom_range(5)) file_bytes.push_back(rand_line_byte());
         file_bytes.push_back($urandom_range(1) ? CHAR_LF : CHAR_CR);
      end else begin
         repeat ($urandom_range(1, 2)) file_bytes.push_back(rand_blank());
      end
   endtask

   // mostly well-formed small images; some truncated, corrupted, zero-sized or pure noise
   task build_random_file();
      int unsigned mode;
      int unsigned w;
      int unsigned h;
      int unsigned maxv;
      int unsigned body_start;
      int unsigned cut;
      int unsigned pos;
      file_bytes.delete();
      mode = $urandom_range(99);
      repeat ($urandom_range(4)) file_bytes.push_back(rand_line_byte());
      if ($urandom_range(3) == 0) file_bytes.push_back(CHAR_CR);
      file_bytes.push_back(CHAR_LF);
      if (mode < 5) begin
         repeat ($urandom_range(3, 12)) file_bytes.push_back(8'($urandom_range(255)));
         return;
      end
      body_start = file_bytes.size();
      w = $urandom_range(1, 4);
      h = $urandom_range(1, 3);
      if (mode < 13) begin
         if ($urandom_range(1)) w = 0;
         else h = 0;
      end
      case ($urandom_range(3))
         0: maxv = 255;
         1: maxv = $urandom_range(65535);
         2: maxv = $urandom_range(999999);
         default: maxv = $urandom_range(15);
      endcase
      if ($urandom_range(1)) add_separator();
      add_number(w);
      add_separator();
      add_number(h);
      add_separator();
      add_number(maxv);
      repeat (w * h * 3) begin
         add_separator();
         add_number(($urandom_range(9) == 0) ? $urandom_range(999999) : $urandom_range(255));
      end
      // the file may end on the final digit, on a blank, or after trailing junk
      case ($urandom_range(2))
         0: ;
         1: add_separator();
         default: begin
            add_separator();
            repeat ($urandom_range(1, 4)) file_bytes.push_back(8'($urandom_range(255)));
         end
      endcase
      if (mode >= 13 && mode < 23) begin
         cut = $urandom_range(file_bytes.size() - 2);
         while (file_bytes.size() > cut + 1) void'(file_bytes.pop_back());
      end else if (mode >= 23 && mode < 31) begin
         pos = $urandom_range(body_start, file_bytes.size() - 1);
         file_bytes.insert(pos, rand_stray_byte());
      end
   endtask

   // -------- tests --------

   task test_directed();
      send_text("\n1 1 0 1 2 3");                      // max value zero, last pixel on tlast
      send_text("x\n2\t1\013255#c\r9\01470000 255\n0 0 0 x"); // comment, wrap, trailing
      send_text("\n99999 99999 99999 \n");             // saturated header, then early end
      send_text("\n0 5 9 1");                          // zero width
      send_text("\n3 0 9\n");                          // zero height
      send_text("\n1 1 9 \377 1 2");                   // stray byte with the top bit set
      send_text("P3");                                 // ends inside the first line
      send_text("\n2 1 5 1 2 3 4");                    // ends inside a pixel
      send_text("\n1 1 7");                            // tlast ends the header
      send_text("\n1 1 7 ~");                          // stray byte on the final byte
   endtask

   task test_random_files(input int target);
      int goal;
      goal = parsed_bytes + target;
      while (parsed_bytes < goal) begin
         build_random_file();
         send_file();
      end
   endtask

   task test_back_to_back(input int target);
      steady = 1'b1;
      test_random_files(target);
      steady = 1'b0;
   endtask

   // -------- result checking --------

   task check_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch in result %0d, %s: expected %0h, got %0h",
                     results_seen, name, want, got);
      end
   endtask

   always @(posedge clock) begin : rsp_check
      ppm_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         case (rsp_tuser)
            KIND_HEADER: header_count++;
            KIND_PIXEL:  pixel_count++;
            default:     error_count++;
         endcase
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d arrived with none expected: kind %0h data %h",
                        results_seen, rsp_tuser, rsp_tdata);
         end else begin
            want = pending_results.pop_front();
            check_field("kind", 16'(want.kind), 16'(rsp_tuser));
            check_field("image_width", want.width, rsp_tdata[15:0]);
            check_field("image_height", want.height, rsp_tdata[31:16]);
            check_field("max_value", want.max_val, rsp_tdata[47:32]);
            check_field("red", 16'(want.red), 16'(rsp_tdata[55:48]));
            check_field("green", 16'(want.green), 16'(rsp_tdata[63:56]));
            check_field("blue", 16'(want.blue), 16'(rsp_tdata[71:64]));
            check_field("error_code", 16'(want.err), 16'(rsp_tdata[73:72]));
            check_field("zero fill", 16'd0, 16'(rsp_tdata[79:74]));
            check_field("last_pixel", 16'(want.last), 16'(rsp_tlast));
         end
      end
      rsp_tready <= steady || ($urandom_range(99) >= 10);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", pending_results.size());
         $display("ppm_ascii_pixel_parser_unit test failed");
         $finish;
      end
   end

   initial begin
      clear_parser();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_files(RANDOM_BYTES);
      test_back_to_back(STEADY_BYTES);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("sent %0d files, %0d bytes (%0d parsed), with random idling and a stall-free run",
               files_sent, bytes_sent, parsed_bytes);
      $display("checked %0d headers, %0d pixels and %0d errors, %0d mismatches",
               header_count, pixel_count, error_count, mismatches);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("ppm_ascii_pixel_parser_unit test passed");
      end else begin
         $display("ppm_ascii_pixel_parser_unit test failed");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/ppu_pkg.sv
hw/rtl/ppu_front.sv
hw/rtl/ppu_queue.sv
hw/rtl/ppu_back.sv
hw/rtl/ppm_ascii_pixel_parser_unit.sv
hw/rtl/ppu_checker.sv
tb/sv/tb_ppm_ascii_pixel_parser_unit.sv
